>>> src/npe_pkg.sv
// shared types and constants for the normalized patch extractor
`timescale 1ns / 1ps
package npe_pkg;

  localparam int MaxRows      = 128;
  localparam int MaxCols      = 128;
  localparam int MaxHalfWidth = 3;

  localparam int RowW   = 7;
  localparam int ColW   = 7;
  localparam int AddrW  = RowW + ColW;
  localparam int PixW   = 8;
  localparam int CntW   = 8;          // row / column count registers
  localparam int HwW    = 2;
  localparam int SideW  = 3;
  localparam int NW     = 6;          // window size up to 49
  localparam int SumW   = 14;         // up to 49 * 255
  localparam int SqW    = 22;         // up to 49 * 255^2
  localparam int DW     = 28;         // n*Q - S*S
  localparam int NumW   = 14;
  localparam int Num2W  = 28;
  localparam int RhsW   = Num2W + 24;
  localparam int MagW   = 16;
  localparam int AccW   = 64;
  localparam int BitW   = 4;          // index of the trial bit
  localparam int QcW    = 16;
  localparam int OutW   = 16;

  localparam logic [MagW-1:0] PosLimit = 16'd32767;
  localparam logic [MagW-1:0] NegLimit = 16'd32768;

  localparam logic [1:0] CfgHalfWidth = 2'd0;
  localparam logic [1:0] CfgImageRows = 2'd1;
  localparam logic [1:0] CfgImageCols = 2'd2;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StRej,
    StSum,
    StSumTail,
    StDiff,
    StDiff2,
    StElRd,
    StElWait,
    StElSq,
    StElGo,
    StElDiv,
    StElOut
  } state_e;

  typedef enum logic {
    PhTrial,
    PhCheck
  } phase_e;

endpackage

>>> src/npe_rdiv.sv
// iterative unit: round(2048*num/sqrt(d)) by bit search with shift-add squares
`timescale 1ns / 1ps
module npe_rdiv import npe_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [RhsW-1:0] rhs_i,
  input  logic [DW-1:0]   d_i,
  input  logic [MagW-1:0] limit_i,
  output logic            done_o,
  output logic [MagW-1:0] mag_o
);

  // a_q = w^2*d, b_q = w*d with w = 2*m; candidate accepted when (w'-1)^2*d <= rhs
  logic [AccW-1:0] a_q, a_d, b_q, b_d, at_q, at_d, bt_q, bt_d;
  logic [MagW-1:0] m_q, m_d, mt_q, mt_d;
  logic [BitW-1:0] k_q, k_d;
  phase_e          ph_q, ph_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [AccW-1:0] d_ext, rhs_ext, chk;
  logic [5:0]      sh_b, sh_d2, sh_d1;

  assign d_ext   = AccW'(d_i);
  assign rhs_ext = AccW'(rhs_i);
  assign sh_b    = 6'(k_q) + 6'd2;
  assign sh_d2   = {1'b0, k_q, 1'b0} + 6'd2;
  assign sh_d1   = 6'(k_q) + 6'd1;
  assign chk     = at_q - (bt_q << 1) + d_ext;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    at_d   = at_q;
    bt_d   = bt_q;
    m_d    = m_q;
    mt_d   = mt_q;
    k_d    = k_q;
    ph_d   = ph_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = '0;
      b_d    = '0;
      m_d    = '0;
      k_d    = BitW'(MagW - 1);
      ph_d   = PhTrial;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ph_q == PhTrial) begin
        at_d = a_q + (b_q << sh_b) + (d_ext << sh_d2);
        bt_d = b_q + (d_ext << sh_d1);
        mt_d = m_q | (MagW'(1) << k_q);
        ph_d = PhCheck;
      end else begin
        if (chk <= rhs_ext && mt_q <= limit_i) begin
          a_d = at_q;
          b_d = bt_q;
          m_d = mt_q;
        end
        ph_d = PhTrial;
        if (k_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= PhTrial;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      ph_q   <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    at_q <= at_d;
    bt_q <= bt_d;
    m_q  <= m_d;
    mt_q <= mt_d;
    k_q  <= k_d;
  end

  assign done_o = done_q;
  assign mag_o  = m_q;

endmodule

>>> src/normalized_patch_extractor_core.sv
// top level: image store, window statistics and per-pixel normalization sequencer
`timescale 1ns / 1ps
// channel   direction  fields                                         transfer when
// in        in         cmd, row, col, pixel                           in_valid_i & in_ready_o
// out       out        query_index, accepted, accepted_count,         out_valid_o & out_ready_i
//                      element_index, norm_value, last
// cfg       in         cfg_index (0 half_width, 1 rows, 2 cols), data cfg_valid_i & cfg_ready_o
//
// a load writes the image on its transfer; a rejected query passes StRej and waits for the output
// an accepted query first makes the statistics pass (StSum, StSumTail, StDiff, StDiff2)
// over the image memory with its one read port (n up to 49), then handles each pixel,
// its time set mostly by the bit-by-bit search of the 16-bit root-division unit
// input is taken only between items; the output register lets the next item in
// while the final result waits; reset clears control and counters, not the image
module normalized_patch_extractor_core import npe_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   cmd_i,
  input  logic [RowW-1:0]        row_i,
  input  logic [ColW-1:0]        col_i,
  input  logic [PixW-1:0]        pixel_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [QcW-1:0]         query_index_o,
  output logic                   accepted_o,
  output logic [QcW-1:0]         accepted_count_o,
  output logic [5:0]             element_index_o,
  output logic signed [OutW-1:0] norm_value_o,
  output logic                   last_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [CntW-1:0]        cfg_data_i
);

  // configuration
  logic [HwW-1:0]  hw_q;
  logic [CntW-1:0] rows_q, cols_q, rows_c, cols_c;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q   <= HwW'(1);
      rows_q <= CntW'(MaxRows);
      cols_q <= CntW'(MaxCols);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgHalfWidth: hw_q   <= cfg_data_i[HwW-1:0];
        CfgImageRows: rows_q <= cfg_data_i;
        CfgImageCols: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rows_c = (rows_q > CntW'(MaxRows)) ? CntW'(MaxRows) : rows_q;
  assign cols_c = (cols_q > CntW'(MaxCols)) ? CntW'(MaxCols) : cols_q;

  // sequencer state
  state_e state_q, state_d;
  logic   in_xfer, out_free, win_last, el_last, div_start, div_done, win_inside, d_zero;

  logic [RowW-1:0]  base_row_q;
  logic [ColW-1:0]  base_col_q;
  logic [SideW-1:0] r_q, c_q, side_q;
  logic [NW-1:0]    n_q, k_q;
  logic [QcW-1:0]   qcnt_q, acnt_q, qidx_q;
  logic             acc_en_q;
  logic [SumW-1:0]  sum_q;
  logic [SqW-1:0]   sq_q;
  logic [DW-1:0]    nq_q, ss_q, d_q;
  logic [NumW-1:0]  num_q, np;
  logic             neg_q;
  logic [Num2W-1:0] num2_q;
  logic [MagW-1:0]  div_mag, mag;
  logic [SideW-1:0] side_in;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_o || out_ready_i;
  assign win_last = (r_q == side_q - 1'b1) && (c_q == side_q - 1'b1);
  assign el_last  = (k_q == n_q - 1'b1);
  assign d_zero   = (d_q == '0);
  assign side_in  = {hw_q, 1'b1};

  // window fully inside the image
  assign win_inside = ({2'b0, col_i} >= 9'(hw_q)) &&
                      ({2'b0, col_i} + 9'(hw_q) < {1'b0, cols_c}) &&
                      ({2'b0, row_i} >= 9'(hw_q)) &&
                      ({2'b0, row_i} + 9'(hw_q) < {1'b0, rows_c});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer && cmd_i == CmdQuery) state_d = win_inside ? StSum : StRej;
      end
      StRej:     if (out_free) state_d = StIdle;
      StSum:     if (win_last) state_d = StSumTail;
      StSumTail: state_d = StDiff;
      StDiff:    state_d = StDiff2;
      StDiff2:   state_d = StElRd;
      StElRd:    state_d = StElWait;
      StElWait:  state_d = StElSq;
      StElSq:    state_d = d_zero ? StElOut : StElGo;
      StElGo:    state_d = StElDiv;
      StElDiv:   if (div_done) state_d = StElOut;
      StElOut: begin
        if (out_free) state_d = el_last ? StIdle : StElRd;
      end
      default:   state_d = StIdle;
    endcase
  end

  // handshake and unit control
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      StIdle:  in_ready_o = 1'b1;
      StElGo:  div_start  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  // image memory: write on load transfers, one registered read port
  logic [PixW-1:0]  mem_q [MaxRows*MaxCols];
  logic [PixW-1:0]  rd_data_q;
  logic [AddrW-1:0] rd_addr;
  logic [RowW-1:0]  win_row;
  logic [ColW-1:0]  win_col;

  assign win_row = base_row_q + RowW'(r_q);
  assign win_col = base_col_q + ColW'(c_q);
  // row-major address, row * MaxCols + col
  assign rd_addr = {win_row, win_col};

  always_ff @(posedge clk_i) begin
    if (in_xfer && cmd_i == CmdLoad) mem_q[{row_i, col_i}] <= pixel_i;
    rd_data_q <= mem_q[rd_addr];
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcnt_q   <= '0;
      acnt_q   <= '0;
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= (state_q == StSum);
      if (in_xfer && cmd_i == CmdQuery) begin
        qcnt_q <= qcnt_q + 1'b1;
        if (win_inside) acnt_q <= acnt_q + 1'b1;
      end
    end
  end

  // window walk, statistics and per-pixel numerator
  assign np = NumW'(n_q * rd_data_q);

  always_ff @(posedge clk_i) begin
    if (in_xfer && cmd_i == CmdQuery) begin
      qidx_q     <= qcnt_q;
      base_row_q <= row_i - RowW'(hw_q);
      base_col_q <= col_i - ColW'(hw_q);
      side_q     <= side_in;
      n_q        <= NW'(side_in * side_in);
      sum_q      <= '0;
      sq_q       <= '0;
      r_q        <= '0;
      c_q        <= '0;
      k_q        <= '0;
    end
    if (acc_en_q) begin
      sum_q <= sum_q + SumW'(rd_data_q);
      sq_q  <= sq_q + SqW'(rd_data_q * rd_data_q);
    end
    // column-major walk: rows fastest
    if (state_q == StSum || (state_q == StElOut && out_free)) begin
      if (r_q == side_q - 1'b1) begin
        r_q <= '0;
        c_q <= c_q + 1'b1;
      end else begin
        r_q <= r_q + 1'b1;
      end
    end
    if (state_q == StSumTail) begin
      r_q <= '0;
      c_q <= '0;
    end
    if (state_q == StElOut && out_free) k_q <= k_q + 1'b1;
    if (state_q == StDiff) begin
      nq_q <= DW'(n_q * sq_q);
      ss_q <= DW'(sum_q * sum_q);
    end
    if (state_q == StDiff2) d_q <= nq_q - ss_q;
    if (state_q == StElWait) begin
      neg_q <= (np < sum_q);
      num_q <= (np < sum_q) ? (sum_q - np) : (np - sum_q);
    end
    if (state_q == StElSq) num2_q <= Num2W'(num_q * num_q);
  end

  npe_rdiv u_rdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rhs_i   ({num2_q, 24'b0}),
    .d_i     (d_q),
    .limit_i (neg_q ? NegLimit : PosLimit),
    .done_o  (div_done),
    .mag_o   (div_mag)
  );

  assign mag = d_zero ? '0 : div_mag;

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == StRej || state_q == StElOut) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StRej && out_free) begin
      query_index_o    <= qidx_q;
      accepted_o       <= 1'b0;
      accepted_count_o <= acnt_q;
      element_index_o  <= '0;
      norm_value_o     <= '0;
      last_o           <= 1'b1;
    end else if (state_q == StElOut && out_free) begin
      query_index_o    <= qidx_q;
      accepted_o       <= 1'b1;
      accepted_count_o <= acnt_q;
      element_index_o  <= k_q;
      norm_value_o     <= neg_q ? OutW'(-mag) : OutW'(mag);
      last_o           <= el_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
